// ===== src/atilt_pkg.sv =====
// Package for the checked accelerometer tilt block.
// Holds widths, constants, the arctangent table and the pipeline payload types.
package atilt_pkg;

  localparam int unsigned Steps      = 25;
  localparam int unsigned SqrtSteps  = 31;
  localparam int unsigned AccW       = 50;
  localparam int unsigned AngW       = 36;
  localparam int unsigned RadW       = 62;
  localparam logic [7:0]  FrameMark  = 8'd88;
  localparam logic signed [14:0] TiltLimit = 15'sd9000;
  localparam int unsigned QDepth     = 4;
  localparam int unsigned QPtrW      = 2;

  typedef struct packed {
    logic              ok;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } frame_t;

  typedef struct packed {
    logic signed [14:0] x_tilt;
    logic signed [14:0] y_tilt;
    logic               frame_ok;
  } result_t;

  // Per-lane state while computing one angle.
  typedef struct packed {
    logic              zero_den;
    logic signed [16:0] num;
    logic [RadW-1:0]   rad;
    logic [31:0]       root;
    logic [RadW-1:0]   rem;
    logic signed [AccW-1:0] a;
    logic signed [AccW-1:0] b;
    logic signed [AngW-1:0] ang;
  } lane_t;

  function automatic logic signed [AngW-1:0] atan_tab(input logic [4:0] i);
    logic signed [AngW-1:0] t;
    case (i)
      5'd0: t = 36'sd294912000;  5'd1: t = 36'sd174096719;
      5'd2: t = 36'sd91987925;   5'd3: t = 36'sd46694507;
      5'd4: t = 36'sd23437865;   5'd5: t = 36'sd11730358;
      5'd6: t = 36'sd5866610;    5'd7: t = 36'sd2933484;
      5'd8: t = 36'sd1466764;    5'd9: t = 36'sd733385;
      5'd10: t = 36'sd366693;    5'd11: t = 36'sd183346;
      5'd12: t = 36'sd91673;     5'd13: t = 36'sd45837;
      5'd14: t = 36'sd22918;     5'd15: t = 36'sd11459;
      5'd16: t = 36'sd5730;      5'd17: t = 36'sd2865;
      5'd18: t = 36'sd1432;      5'd19: t = 36'sd716;
      5'd20: t = 36'sd358;       5'd21: t = 36'sd179;
      5'd22: t = 36'sd90;        5'd23: t = 36'sd45;
      5'd24: t = 36'sd22;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// ===== src/atilt_if.sv =====
// Valid/ready stream interfaces for the tilt block.
// Declared with plain logic signals; atilt_pkg is not used here.
interface atilt_in_if;
  logic              valid;
  logic              ready;
  logic [7:0]        marker;
  logic signed [15:0] x_raw;
  logic signed [15:0] y_raw;
  logic signed [15:0] z_raw;
  logic signed [17:0] frame_sum;
  modport source (output valid, marker, x_raw, y_raw, z_raw, frame_sum, input ready);
  modport sink (input valid, marker, x_raw, y_raw, z_raw, frame_sum, output ready);
endinterface

interface atilt_out_if;
  logic              valid;
  logic              ready;
  logic signed [14:0] x_tilt;
  logic signed [14:0] y_tilt;
  logic              frame_ok;
  modport source (output valid, x_tilt, y_tilt, frame_ok, input ready);
  modport sink (input valid, x_tilt, y_tilt, frame_ok, output ready);
endinterface

// ===== src/atilt_front.sv =====
// Front end: accepts frames, checks marker and sum, writes classified frames to a queue.
// Depends on atilt_pkg.
module atilt_front import atilt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  atilt_in_if.sink in_ch,
  output frame_t q_data,
  output logic   q_valid,
  input  logic   q_ready
);

  frame_t mem [QDepth];
  logic [QPtrW-1:0] wr_ptr, rd_ptr;
  logic [QPtrW:0]   count;
  logic push, pop, ok;
  logic signed [17:0] sum;

  // Check the frame; the queue write below zeroes the axes of a bad one.
  always_comb begin
    sum = 18'(in_ch.x_raw) + 18'(in_ch.y_raw) + 18'(in_ch.z_raw);
    ok  = (in_ch.marker == FrameMark) && (sum == in_ch.frame_sum);
  end

  assign in_ch.ready = (count != (QPtrW+1)'(QDepth));
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (count != '0);
  assign pop = q_valid && q_ready;
  assign q_data = mem[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr].ok <= ok;
      mem[wr_ptr].x  <= ok ? in_ch.x_raw : '0;
      mem[wr_ptr].y  <= ok ? in_ch.y_raw : '0;
      mem[wr_ptr].z  <= ok ? in_ch.z_raw : '0;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (QPtrW+1)'(QDepth)) else $error("queue overflow");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1) else $error("count slip");
  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> wr_ptr == rd_ptr) else $error("pointer mismatch");
`endif

endmodule

// ===== src/atilt_back.sv =====
// Back end: pipelined square root and vectoring CORDIC for both tilt angles.
// Depends on atilt_pkg; output register stage feeds the result channel.
module atilt_back import atilt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  frame_t q_data,
  input  logic   q_valid,
  output logic   q_ready,
  atilt_out_if.source out_ch
);

  localparam int unsigned Depth = SqrtSteps + Steps + 1;

  logic [Depth:0] vld;
  logic           adv;
  lane_t  lx [Depth+1];
  lane_t  ly [Depth+1];
  logic   okp [Depth+1];

  // The pipeline moves whenever its last stage is free or being drained.
  assign adv = !vld[Depth] || out_ch.ready;
  assign q_ready = adv;

  function automatic lane_t lane_init(input logic signed [15:0] n,
                                      input logic signed [15:0] p,
                                      input logic signed [15:0] q);
    lane_t l;
    logic [31:0] sq;
    sq = 32'(p * p) + 32'(q * q);
    l = '0;
    l.num = 17'(n);
    l.zero_den = (sq == '0);
    l.rad = RadW'(sq) << 30;
    return l;
  endfunction

  // One digit of the integer square root, from the top bit pair down.
  function automatic lane_t sqrt_step(input lane_t l, input int unsigned k);
    lane_t o;
    logic [RadW-1:0] trial;
    logic [RadW-1:0] rem2;
    o = l;
    rem2 = (l.rem << 2) | RadW'((l.rad >> (2*(SqrtSteps-1-k))) & 62'd3);
    trial = (RadW'(l.root) << 2) | 62'd1;
    if (rem2 >= trial) begin
      o.rem = rem2 - trial;
      o.root = (l.root << 1) | 32'd1;
    end else begin
      o.rem = rem2;
      o.root = l.root << 1;
    end
    if (k == SqrtSteps-1) begin
      o.a = AccW'(o.root);
      o.b = AccW'(l.num) <<< 15;
    end
    return o;
  endfunction

  function automatic lane_t cordic_step(input lane_t l, input int unsigned i);
    lane_t o;
    o = l;
    if (l.b > 0) begin
      o.a = l.a + (l.b >>> i);
      o.b = l.b - (l.a >>> i);
      o.ang = l.ang + atan_tab(5'(i));
    end else begin
      o.a = l.a - (l.b >>> i);
      o.b = l.b + (l.a >>> i);
      o.ang = l.ang - atan_tab(5'(i));
    end
    return o;
  endfunction

  function automatic logic signed [14:0] finish(input lane_t l);
    logic [AngW-1:0] m;
    logic [AngW-1:0] r;
    logic signed [14:0] t;
    if (l.zero_den) begin
      if (l.num > 0) t = TiltLimit;
      else if (l.num < 0) t = -TiltLimit;
      else t = '0;
    end else begin
      m = l.ang < 0 ? AngW'(-l.ang) : AngW'(l.ang);
      r = (m + AngW'(32768)) >> 16;
      t = (r > AngW'(9000)) ? TiltLimit : 15'(r);
      if (l.ang < 0) t = -t;
    end
    return t;
  endfunction

  // Stage 0 squares the axes; then square root digits, CORDIC steps and a final copy stage.
  always_ff @(posedge clk) begin
    if (adv) begin
      lx[0]  <= lane_init(q_data.x, q_data.y, q_data.z);
      ly[0]  <= lane_init(q_data.y, q_data.x, q_data.z);
      okp[0] <= q_data.ok;
      for (int unsigned s = 0; s < Depth; s++) begin
        okp[s+1] <= okp[s];
        if (s < SqrtSteps) begin
          lx[s+1] <= sqrt_step(lx[s], s);
          ly[s+1] <= sqrt_step(ly[s], s);
        end else if (s < SqrtSteps + Steps) begin
          lx[s+1] <= cordic_step(lx[s], s - SqrtSteps);
          ly[s+1] <= cordic_step(ly[s], s - SqrtSteps);
        end else begin
          lx[s+1] <= lx[s];
          ly[s+1] <= ly[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[Depth-1:0], q_valid};
  end

  assign out_ch.valid    = vld[Depth];
  assign out_ch.x_tilt   = finish(lx[Depth]);
  assign out_ch.y_tilt   = finish(ly[Depth]);
  assign out_ch.frame_ok = okp[Depth];

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    vld[Depth] && !out_ch.ready |=> vld[Depth]) else $error("result dropped");
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    vld[Depth] && !okp[Depth] |-> out_ch.x_tilt == '0 && out_ch.y_tilt == '0)
    else $error("bad frame gave nonzero tilt");
  a_range: assert property (@(posedge clk) disable iff (rst)
    vld[Depth] |-> out_ch.x_tilt <= TiltLimit && out_ch.x_tilt >= -TiltLimit)
    else $error("tilt out of range");
`endif

endmodule

// ===== src/accel_tilt_angle_checked_top.sv =====
// Top level of the checked accelerometer tilt block.
// Depends on atilt_pkg, atilt_if, atilt_front and atilt_back.
//
// in_ch carries one frame per beat: marker, three axis counts and their sum.
// out_ch carries one result per frame: X and Y tilt in hundredths of a
// degree and a flag that the frame passed its marker and sum check.
// Throughput is one frame per cycle while out_ch.ready is high. From an accepted
// input beat, a frame passes through the queue, the squaring stage, 31 square
// root digit stages and 25 CORDIC stages, after which the output stage
// offers the result.
// The front queue holds four frames; the back pipeline freezes while the
// result is not taken, and the queue then fills before in_ch.ready falls.
// A synchronous reset empties the queue and clears all valid bits; no
// clearing pass is needed.
module accel_tilt_angle_checked_top import atilt_pkg::*; (
  input logic clk,
  input logic rst,
  atilt_in_if.sink    in_ch,
  atilt_out_if.source out_ch
);

  frame_t q_data;
  logic   q_valid, q_ready;

  atilt_front u_front (.clk, .rst, .in_ch, .q_data, .q_valid, .q_ready);
  atilt_back  u_back  (.clk, .rst, .q_data, .q_valid, .q_ready, .out_ch);

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the checked accelerometer tilt block.
// Depends on atilt_pkg, atilt_if and accel_tilt_angle_checked_top.
module tb;
  import atilt_pkg::*;

  localparam int Latency = 58;
  localparam int CycleLimit = 400000;

  typedef struct {
    logic [7:0]         marker;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic signed [17:0] sum;
    bit                 typed;
    result_t            res;
  } frame_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  int   errors = 0;
  bit   calm = 1'b0;

  atilt_in_if  in_ch();
  atilt_out_if out_ch();

  accel_tilt_angle_checked_top dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  result_t tilts_due[$];

  // Arctangent of one axis against the magnitude of the other two, as a CORDIC.
  function automatic logic signed [14:0] tilt_of(longint n, longint p, longint q);
    longint sq, a, b, ang, da, db, mag, r, s, root, bitv;
    sq = p * p + q * q;
    if (sq == 0) begin
      return (n > 0) ? TiltLimit : (n < 0) ? -TiltLimit : 15'sd0;
    end
    // Integer square root of sq scaled by 2^30.
    s = sq << 30;
    root = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s = s - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    a = root;
    b = n * 32768;
    ang = 0;
    for (int i = 0; i < Steps; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (b > 0) begin
        a += da; b -= db; ang += atan_tab(5'(i));
      end else begin
        a -= da; b += db; ang -= atan_tab(5'(i));
      end
    end
    mag = (ang < 0) ? -ang : ang;
    r = (mag + 32768) >> 16;
    if (r > 9000) r = 9000;
    return 15'((ang < 0) ? -r : r);
  endfunction

  function automatic result_t tilts_of(frame_row_t f);
    result_t o;
    longint x, y, z;
    bit good;
    good = (f.marker == FrameMark) &&
           (longint'(f.x) + longint'(f.y) + longint'(f.z) == longint'(f.sum));
    x = good ? longint'(f.x) : 0;
    y = good ? longint'(f.y) : 0;
    z = good ? longint'(f.z) : 0;
    o.x_tilt = tilt_of(x, y, z);
    o.y_tilt = tilt_of(y, x, z);
    o.frame_ok = good;
    return o;
  endfunction

  // Drive one frame and wait for its beat, with random gaps before it.
  task automatic send_frame(frame_row_t f);
    result_t e;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    e = f.typed ? f.res : tilts_of(f);
    in_ch.valid <= 1'b1;
    in_ch.marker <= f.marker;
    in_ch.x_raw <= f.x;
    in_ch.y_raw <= f.y;
    in_ch.z_raw <= f.z;
    in_ch.frame_sum <= f.sum;
    do @(posedge clk); while (!in_ch.ready);
    tilts_due.push_back(e);
  endtask

  function automatic frame_row_t good_frame(int x, int y, int z);
    frame_row_t f;
    f.marker = FrameMark;
    f.x = 16'(x); f.y = 16'(y); f.z = 16'(z);
    f.sum = 18'(x + y + z);
    f.typed = 1'b0;
    return f;
  endfunction

  // Result side: random stalls, compare each beat with the oldest expectation.
  initial begin
    result_t e;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        if (tilts_due.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          e = tilts_due.pop_front();
          if (out_ch.x_tilt !== e.x_tilt) begin
            $error("x_tilt: expected %0d, got %0d", e.x_tilt, out_ch.x_tilt); errors++;
          end
          if (out_ch.y_tilt !== e.y_tilt) begin
            $error("y_tilt: expected %0d, got %0d", e.y_tilt, out_ch.y_tilt); errors++;
          end
          if (out_ch.frame_ok !== e.frame_ok) begin
            $error("frame_ok: expected %0d, got %0d", e.frame_ok, out_ch.frame_ok);
            errors++;
          end
        end
      end
      if (calm || $urandom_range(0, 7) != 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(posedge clk);
      end
    end
  end

  // Watchdog on total cycles.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    frame_row_t rows[$];
    frame_row_t f;
    result_t zero_bad;
    int x, y, z, kind;
    in_ch.valid = 1'b0;
    in_ch.marker = '0;
    in_ch.x_raw = '0;
    in_ch.y_raw = '0;
    in_ch.z_raw = '0;
    in_ch.frame_sum = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed rows: most bad frames and degenerate cases are typed in; the rest use tilts_of.
    zero_bad = '{x_tilt: 15'sd0, y_tilt: 15'sd0, frame_ok: 1'b0};
    f = good_frame(100, 200, 300); f.marker = 8'd0;   f.typed = 1'b1; f.res = zero_bad;
    rows.push_back(f);
    f = good_frame(-5, 7, 9);      f.marker = 8'd255; f.typed = 1'b1; f.res = zero_bad;
    rows.push_back(f);
    f = good_frame(100, 200, 300); f.sum = 18'sd601;  f.typed = 1'b1; f.res = zero_bad;
    rows.push_back(f);
    f = good_frame(0, 0, 0); f.typed = 1'b1; f.res = '{15'sd0, 15'sd0, 1'b1};
    rows.push_back(f);
    f = good_frame(500, 0, 0); f.typed = 1'b1; f.res = '{15'sd9000, 15'sd0, 1'b1};
    rows.push_back(f);
    f = good_frame(-32768, 0, 0); f.typed = 1'b1; f.res = '{-15'sd9000, 15'sd0, 1'b1};
    rows.push_back(f);
    f = good_frame(0, 32767, 0); f.typed = 1'b1; f.res = '{15'sd0, 15'sd9000, 1'b1};
    rows.push_back(f);
    f = good_frame(0, 0, -32768); f.typed = 1'b1; f.res = '{15'sd0, 15'sd0, 1'b1};
    rows.push_back(f);
    rows.push_back(good_frame(32767, 32767, 32767));
    rows.push_back(good_frame(-32768, -32768, -32768));
    rows.push_back(good_frame(32767, -32768, 1));
    rows.push_back(good_frame(1, 1, 0));
    rows.push_back(good_frame(-1, 1, 1));
    rows.push_back(good_frame(16384, -16384, 0));
    f = good_frame(-32768, -32768, -32768); f.sum = 18'sd131071; rows.push_back(f);
    foreach (rows[i]) send_frame(rows[i]);

    // Random frames: mostly well-formed, some broken marker or sum.
    for (int n = 0; n < 1850; n++) begin
      if (n == 900) begin
        in_ch.valid <= 1'b0;
        wait (tilts_due.size() == 0);
        @(posedge clk);
      end
      if (n == 1600) calm = 1'b1;
      kind = $urandom_range(0, 9);
      case ($urandom_range(0, 3))
        0: begin x = $urandom_range(0, 65535) - 32768; y = $urandom_range(0, 65535) - 32768;
                 z = $urandom_range(0, 65535) - 32768; end
        1: begin x = $urandom_range(0, 8) - 4; y = $urandom_range(0, 8) - 4;
                 z = $urandom_range(0, 8) - 4; end
        2: begin x = $urandom_range(0, 65535) - 32768; y = $urandom_range(0, 2) - 1; z = 0; end
        default: begin x = $urandom_range(0, 4095) - 2048; y = $urandom_range(0, 4095) - 2048;
                 z = $urandom_range(0, 4095) - 2048; end
      endcase
      f = good_frame(x, y, z);
      if (kind == 0) f.marker = 8'($urandom_range(0, 255));
      else if (kind == 1) f.sum = 18'($urandom_range(0, 262143));
      send_frame(f);
    end
    in_ch.valid <= 1'b0;

    wait (tilts_due.size() == 0);
    repeat (Latency + 10) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== accel_tilt_angle_checked_top.f =====
src/atilt_pkg.sv
src/atilt_if.sv
src/atilt_front.sv
src/atilt_back.sv
src/accel_tilt_angle_checked_top.sv
verif/tb.sv
